// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/dma_dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dma_dtb_pkg
// Types, constants and control store for the descriptor table builder.
// ----------------------------------------------------------------------------
package dma_dtb_pkg;

  localparam int MaxDescriptors = 16;
  localparam int NumWidth = $clog2(MaxDescriptors + 1);

  localparam int AddrWidth = 32;
  localparam int CountWidth = 16;
  localparam int BlockWidth = 13;
  localparam int BytesWidth = 17;
  localparam int LeftWidth = CountWidth + BlockWidth;

  localparam logic [BytesWidth-1:0] RegionMax = 17'h10000;
  localparam logic [BlockWidth-1:0] BlockBytesReset = 13'd512;

  typedef enum logic {
    REG_BLOCK_BYTES = 1'b0,
    REG_BUS_MASTER  = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ODD       = 3'd1,
    ST_NO_MASTER = 3'd2,
    ST_ZERO      = 3'd3,
    ST_TOO_MANY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_CHK_ODD  = 3'd1,
    STEP_CHK_BM   = 3'd2,
    STEP_CHK_ZERO = 3'd3,
    STEP_EMIT     = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    COND_START = 3'd0,
    COND_ODD   = 3'd1,
    COND_NO_BM = 3'd2,
    COND_ZERO  = 3'd3,
    COND_FULL  = 3'd4
  } cond_t;

  typedef struct packed {
    cond_t   cond;
    logic    emit_err;
    status_t err;
    logic    load;
    logic    mul;
    logic    emit_desc;
    step_t   jump_true;
    step_t   jump_false;
    step_t   jump_last;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t c;
    c = '{cond: COND_START, emit_err: 1'b0, err: ST_OK, load: 1'b0, mul: 1'b0,
          emit_desc: 1'b0, jump_true: STEP_IDLE, jump_false: STEP_IDLE,
          jump_last: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        c.cond = COND_START;
        c.load = 1'b1;
        c.jump_true = STEP_CHK_ODD;
        c.jump_false = STEP_IDLE;
      end
      STEP_CHK_ODD: begin
        c.cond = COND_ODD;
        c.emit_err = 1'b1;
        c.err = ST_ODD;
        c.mul = 1'b1;
        c.jump_false = STEP_CHK_BM;
      end
      STEP_CHK_BM: begin
        c.cond = COND_NO_BM;
        c.emit_err = 1'b1;
        c.err = ST_NO_MASTER;
        c.jump_false = STEP_CHK_ZERO;
      end
      STEP_CHK_ZERO: begin
        c.cond = COND_ZERO;
        c.emit_err = 1'b1;
        c.err = ST_ZERO;
        c.jump_false = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.cond = COND_FULL;
        c.emit_err = 1'b1;
        c.err = ST_TOO_MANY;
        c.emit_desc = 1'b1;
        c.jump_false = STEP_EMIT;
        c.jump_last = STEP_IDLE;
      end
      default: begin
        c.jump_true = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/dma_descriptor_table_builder_unit.sv =====
// ----------------------------------------------------------------------------
// dma_descriptor_table_builder_unit
// Splits a block transfer into 64 KiB-bounded region descriptors.
// ----------------------------------------------------------------------------
// Sequence: after accept the control sequencer checks for an odd address,
//   then a missing bus master, then zero length; a failing check ends the
//   run with its error beat. It then emits descriptors until the last one
//   or the too-many error, one step per cycle; start is taken only in idle.
// Reset: registers return to block_bytes 512, bus master absent, idle.
// Results are one-cycle strobed beats; the receiver cannot stall.
module dma_descriptor_table_builder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] buffer_addr,
  input  logic [15:0] block_count,
  input  logic        write_dir,
  output logic        result_valid,
  output logic [31:0] desc_addr,
  output logic [16:0] desc_bytes,
  output logic        table_end,
  output logic        memory_write,
  output logic [2:0]  status,
  output logic        run_last
);

  `include "assert_macros.svh"

  localparam int AW = dma_dtb_pkg::AddrWidth;
  localparam int CW = dma_dtb_pkg::CountWidth;
  localparam int BW = dma_dtb_pkg::BlockWidth;
  localparam int YW = dma_dtb_pkg::BytesWidth;
  localparam int LW = dma_dtb_pkg::LeftWidth;
  localparam int NW = dma_dtb_pkg::NumWidth;

  logic [BW-1:0] block_bytes;
  logic          bus_master_present;

  dma_dtb_pkg::step_t step, step_next;
  dma_dtb_pkg::ctrl_t ctrl;

  logic [AW-1:0] addr, addr_next;
  logic [CW-1:0] count, count_next;
  logic [LW-1:0] left, left_next;
  logic [NW-1:0] num, num_next;
  logic          mem_wr, mem_wr_next;

  logic          cond_true;
  logic [YW-1:0] room;
  logic [YW-1:0] chunk;
  logic          last;

  logic                valid_next;
  logic [AW-1:0]       out_addr_next;
  logic [YW-1:0]       out_bytes_next;
  logic                out_end_next;
  logic                out_mw_next;
  dma_dtb_pkg::status_t out_status_next;
  logic                out_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= dma_dtb_pkg::BlockBytesReset;
      bus_master_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (dma_dtb_pkg::reg_index_t'(cfg_index))
        dma_dtb_pkg::REG_BLOCK_BYTES: block_bytes <= cfg_data;
        dma_dtb_pkg::REG_BUS_MASTER: bus_master_present <= cfg_data[0];
        default: block_bytes <= block_bytes;
      endcase
    end
  end

  assign ctrl = dma_dtb_pkg::ucode(step);
  assign busy = (step != dma_dtb_pkg::STEP_IDLE);

  assign room = dma_dtb_pkg::RegionMax - {1'b0, addr[15:0]};
  assign chunk = (left < LW'(room)) ? left[YW-1:0] : room;
  assign last = (left == LW'(chunk));

  always_comb begin
    unique case (ctrl.cond)
      dma_dtb_pkg::COND_START: cond_true = start;
      dma_dtb_pkg::COND_ODD:   cond_true = addr[0];
      dma_dtb_pkg::COND_NO_BM: cond_true = !bus_master_present;
      dma_dtb_pkg::COND_ZERO:  cond_true = (left == '0);
      dma_dtb_pkg::COND_FULL:  cond_true = (num == NW'(dma_dtb_pkg::MaxDescriptors));
      default:                 cond_true = 1'b0;
    endcase
  end

  always_comb begin
    step_next = step;
    addr_next = addr;
    count_next = count;
    left_next = left;
    num_next = num;
    mem_wr_next = mem_wr;
    valid_next = 1'b0;
    out_addr_next = '0;
    out_bytes_next = '0;
    out_end_next = 1'b0;
    out_mw_next = 1'b0;
    out_status_next = dma_dtb_pkg::ST_OK;
    out_last_next = 1'b0;

    if (ctrl.mul) begin
      left_next = LW'(count) * LW'(block_bytes);
    end

    if (cond_true) begin
      step_next = ctrl.jump_true;
      if (ctrl.load) begin
        addr_next = buffer_addr;
        count_next = block_count;
        mem_wr_next = !write_dir;
        num_next = '0;
      end
      if (ctrl.emit_err) begin
        valid_next = 1'b1;
        out_status_next = ctrl.err;
        out_last_next = 1'b1;
      end
    end else begin
      step_next = ctrl.jump_false;
      if (ctrl.emit_desc) begin
        valid_next = 1'b1;
        out_addr_next = addr;
        out_bytes_next = chunk;
        out_end_next = last;
        out_mw_next = mem_wr;
        out_last_next = last;
        addr_next = addr + AW'(chunk);
        left_next = left - LW'(chunk);
        num_next = num + NW'(1);
        if (last) begin
          step_next = ctrl.jump_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dma_dtb_pkg::STEP_IDLE;
      result_valid <= 1'b0;
    end else begin
      step <= step_next;
      result_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    count <= count_next;
    left <= left_next;
    num <= num_next;
    mem_wr <= mem_wr_next;
    desc_addr <= out_addr_next;
    desc_bytes <= out_bytes_next;
    table_end <= out_end_next;
    memory_write <= out_mw_next;
    status <= out_status_next;
    run_last <= out_last_next;
  end

  `ASSERT_IMPLY(a_err_ends_run, clk, rst,
    result_valid && (status != dma_dtb_pkg::ST_OK), run_last)
  `ASSERT_IMPLY(a_end_is_ok_last, clk, rst,
    result_valid && table_end, run_last && (status == dma_dtb_pkg::ST_OK))
  `ASSERT_CLK(a_num_bounded, clk, rst,
    !busy || (num <= NW'(dma_dtb_pkg::MaxDescriptors)))
  `ASSERT_IMPLY(a_busy_from_start, clk, rst,
    $rose(busy), $past(start))

endmodule
